// ----- sv/itsm_pkg.sv -----
package itsm_pkg;

	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int TMR_W   = 16;
	localparam int SCALE_W = 5;
	localparam int SEL_W   = 5;
	localparam int SF_W    = 10;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd2;

	// Operation codes.
	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_ABORT  = 3'd1;
	localparam logic [2:0] OP_FINISH = 3'd2;
	localparam logic [2:0] OP_MOVE   = 3'd3;
	localparam logic [2:0] OP_IRQ    = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	// Fixed statistic indexes ahead of the per-phase blocks.
	localparam logic [SEL_W-1:0] STAT_START    = 5'd0;
	localparam logic [SEL_W-1:0] STAT_END      = 5'd1;
	localparam logic [SEL_W-1:0] STAT_WRAPS    = 5'd2;
	localparam logic [SEL_W-1:0] STAT_DURATION = 5'd3;
	localparam logic [SEL_W-1:0] STAT_ENTRIES  = 5'd4;
	localparam int               STAT_PHASE_BASE = 5;

	// Statistic indexes after the per-phase blocks, relative to their base.
	localparam logic [5:0] ST_OVERALL_MAX   = 6'd0;
	localparam logic [5:0] ST_PULSES        = 6'd1;
	localparam logic [5:0] ST_PENDING       = 6'd2;
	localparam logic [5:0] ST_LONGEST       = 6'd3;
	localparam logic [5:0] ST_IRQ_SAMPLES   = 6'd4;
	localparam logic [5:0] ST_IRQ_MISSING   = 6'd5;
	localparam logic [5:0] ST_IRQ_ACTIVE    = 6'd6;
	localparam logic [5:0] ST_IRQ_TERMINAL  = 6'd7;
	localparam logic [5:0] ST_ENTRY_CNT_MAX = 6'd8;
	localparam logic [5:0] ST_DL_SAMPLES    = 6'd9;
	localparam logic [5:0] ST_DL_MISSES     = 6'd10;
	localparam logic [5:0] ST_LEAST_SLACK   = 6'd11;

	// Sticky saturation flag positions.
	localparam int SF_WRAP      = 0;
	localparam int SF_ENTRIES   = 1;
	localparam int SF_PHASE     = 2;
	localparam int SF_PULSES    = 3;
	localparam int SF_PENDING   = 4;
	localparam int SF_STREAK    = 5;
	localparam int SF_MISSING   = 6;
	localparam int SF_IRQ       = 7;
	localparam int SF_DL_MISSES = 8;
	localparam int SF_DL_SAMPLE = 9;

	// Move flag and irq flag bit positions.
	localparam int MF_PENDING  = 0;
	localparam int MF_PULSE    = 1;
	localparam int MF_COMPLETE = 2;
	localparam int IF_ENTRY    = 0;
	localparam int IF_ETIMER   = 1;
	localparam int IF_PTIMER   = 2;
	localparam int IF_PENDING  = 3;
	localparam int IF_TERMINAL = 4;

	typedef struct packed {
		logic [2:0]         op;
		logic [STAMP_W-1:0] first_cycle;
		logic [STAMP_W-1:0] second_cycle;
		logic [1:0]         phase;
		logic [2:0]         move_flags;
		logic               abort_flag;
		logic [4:0]         irq_flags;
		logic [TMR_W-1:0]   entry_timer_count;
		logic [TMR_W-1:0]   entry_timer_reload;
		logic [TMR_W-1:0]   post_timer_count;
		logic [TMR_W-1:0]   post_timer_reload;
		logic [SEL_W-1:0]   stat_select;
	} item_t;

	typedef struct packed {
		logic [63:0]     read_value;
		logic            run_valid;
		logic            run_active;
		logic            run_aborted;
		logic [SF_W-1:0] saturation_flags;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ----- sv/itsm_chan_if.sv -----
interface itsm_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/isr_timing_statistics_monitor_unit.sv -----
// Interrupt-timing statistics monitor.
// The input channel evt carries one event word per transfer: start, abort,
// finish, move sample, full interrupt sample or statistic read. The output
// channel res returns exactly one result word per event: the read value (zero
// unless the event was a read) with the run status and sticky saturation flags
// as they stand after the event. Both channels move a word when valid and
// ready are high at a rising edge of clk.
// An accepted word sits in the input register while the statistics update
// and the result are formed; the result register loads from it when the word
// advances, and the result is offered from there. One word is accepted every
// cycle as long as the receiver keeps up.
// When res is stalled, the input register still drains into a free result
// register, and only once both are full does evt.ready drop.
// The tick scale register is written through cfg_write/cfg_data; the user
// must write it only while the monitor is idle, which the block itself does
// not enforce. arst_n clears all statistics, sets the least slack to all
// ones and the tick scale to two, and empties both registers.
module isr_timing_statistics_monitor_unit #(
	parameter int PHASE_COUNT = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	itsm_chan_if.sink                    evt,
	itsm_chan_if.source                  res,
	input  logic                         cfg_write,
	input  logic [itsm_pkg::SCALE_W-1:0] cfg_data
);
	import itsm_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic               valid_s1;
	item_t              item_s1;
	logic               out_valid_q;
	result_t            out_q;
	result_t            result;
	logic               adv;

	// The held word moves on whenever the result register is empty or is
	// being emptied in this cycle.
	assign adv       = valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !valid_s1 || adv;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_write) begin
			scale_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1 <= evt.data;
		end
		if (adv) begin
			out_q <= result;
		end
	end

	itsm_core #(
		.PHASE_COUNT(PHASE_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.scale  (scale_q),
		.result (result)
	);

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> evt.ready)
		else $error("input register empty but not ready");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |=> valid_s1)
		else $error("accepted word did not reach the input register");

	a_adv_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_active_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!out_q.run_active && !out_q.run_aborted) || out_q.run_valid))
		else $error("run status active or aborted without a valid run");
`endif

endmodule

// ----- sv/itsm_core.sv -----
module itsm_core #(
	parameter int PHASE_COUNT = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  itsm_pkg::item_t                item,
	input  logic [itsm_pkg::SCALE_W-1:0]   scale,
	output itsm_pkg::result_t              result
);
	import itsm_pkg::*;

	localparam logic [5:0] OTHER_BASE = 6'(STAT_PHASE_BASE + 2 * PHASE_COUNT);

	logic               run_valid_q, run_active_q, run_aborted_q;
	logic [STAMP_W-1:0] start_q, end_q, last_q;
	logic [CNT_W-1:0]   wrap_q, entries_q, overall_max_q, pulses_q, pending_q;
	logic [CNT_W-1:0]   streak_q, longest_q, irq_samples_q, irq_missing_q;
	logic [CNT_W-1:0]   irq_active_q, irq_term_q, dl_samples_q, dl_misses_q, least_q;
	logic [TMR_W-1:0]   ecount_max_q;
	logic [SF_W-1:0]    sticky_q;
	logic [CNT_W-1:0]   ph_cnt_q [PHASE_COUNT];
	logic [CNT_W-1:0]   ph_max_q [PHASE_COUNT];

	logic               run_valid_d, run_active_d, run_aborted_d;
	logic [STAMP_W-1:0] start_d, end_d, last_d;
	logic [CNT_W-1:0]   wrap_d, entries_d, overall_max_d, pulses_d, pending_d;
	logic [CNT_W-1:0]   streak_d, longest_d, irq_samples_d, irq_missing_d;
	logic [CNT_W-1:0]   irq_active_d, irq_term_d, dl_samples_d, dl_misses_d, least_d;
	logic [TMR_W-1:0]   ecount_max_d;
	logic [SF_W-1:0]    sticky_d;
	logic [CNT_W-1:0]   ph_cnt_d [PHASE_COUNT];
	logic [CNT_W-1:0]   ph_max_d [PHASE_COUNT];

	logic                   is_start, move_en;
	logic [STAMP_W-1:0]     elapsed;
	logic [PHASE_COUNT-1:0] ph_hit, ph_sat;
	logic [63:0]            rd_lane [PHASE_COUNT];
	logic [63:0]            rd_phase;

	assign is_start = (item.op == OP_START);
	assign move_en  = (item.op == OP_MOVE) && run_valid_q && run_active_q;
	assign elapsed  = item.second_cycle - item.first_cycle;

	// Per-phase lanes: each lane owns its entry count and maximum.
	for (genvar i = 0; i < PHASE_COUNT; i++) begin : g_phase
		assign ph_hit[i] = (int'(item.phase) == i);
		assign ph_sat[i] = move_en && ph_hit[i] && (ph_cnt_q[i] == '1);

		always_comb begin
			ph_cnt_d[i] = ph_cnt_q[i];
			ph_max_d[i] = ph_max_q[i];
			if (is_start) begin
				ph_cnt_d[i] = '0;
				ph_max_d[i] = '0;
			end else if (move_en && ph_hit[i]) begin
				ph_cnt_d[i] = sat_inc(ph_cnt_q[i]);
				if (elapsed > ph_max_q[i]) begin
					ph_max_d[i] = elapsed;
				end
			end
		end

		always_comb begin
			rd_lane[i] = '0;
			if (int'(item.stat_select) == STAT_PHASE_BASE + i) begin
				rd_lane[i] = 64'(ph_cnt_q[i]);
			end else if (int'(item.stat_select) == STAT_PHASE_BASE + PHASE_COUNT + i) begin
				rd_lane[i] = 64'(ph_max_q[i]);
			end
		end
	end

	always_comb begin
		rd_phase = '0;
		for (int i = 0; i < PHASE_COUNT; i++) begin
			rd_phase = rd_phase | rd_lane[i];
		end
	end

	// Next state of everything outside the phase lanes.
	always_comb begin
		logic [TMR_W:0]   span;
		logic [21:0]      prod;
		logic [CNT_W-1:0] slack;

		run_valid_d   = run_valid_q;
		run_active_d  = run_active_q;
		run_aborted_d = run_aborted_q;
		start_d       = start_q;
		end_d         = end_q;
		last_d        = last_q;
		wrap_d        = wrap_q;
		entries_d     = entries_q;
		overall_max_d = overall_max_q;
		pulses_d      = pulses_q;
		pending_d     = pending_q;
		streak_d      = streak_q;
		longest_d     = longest_q;
		irq_samples_d = irq_samples_q;
		irq_missing_d = irq_missing_q;
		irq_active_d  = irq_active_q;
		irq_term_d    = irq_term_q;
		ecount_max_d  = ecount_max_q;
		dl_samples_d  = dl_samples_q;
		dl_misses_d   = dl_misses_q;
		least_d       = least_q;
		sticky_d      = sticky_q;

		span  = {1'b0, item.post_timer_reload} - {1'b0, item.post_timer_count}
			+ (TMR_W + 1)'(1);
		prod  = 22'(span) * 22'(scale);
		slack = CNT_W'(prod);

		case (item.op)
			OP_START: begin
				run_valid_d   = 1'b1;
				run_active_d  = 1'b1;
				run_aborted_d = 1'b0;
				start_d       = item.first_cycle;
				end_d         = item.first_cycle;
				last_d        = item.first_cycle;
				wrap_d        = '0;
				entries_d     = '0;
				overall_max_d = '0;
				pulses_d      = '0;
				pending_d     = '0;
				streak_d      = '0;
				longest_d     = '0;
				irq_samples_d = '0;
				irq_missing_d = '0;
				irq_active_d  = '0;
				irq_term_d    = '0;
				ecount_max_d  = '0;
				dl_samples_d  = '0;
				dl_misses_d   = '0;
				least_d       = '1;
				sticky_d      = '0;
			end
			OP_ABORT: begin
				if (run_valid_q) begin
					run_aborted_d = 1'b1;
				end
			end
			OP_FINISH: begin
				if (run_valid_q) begin
					if (item.first_cycle < last_q) begin
						if (wrap_q == '1) sticky_d[SF_WRAP] = 1'b1;
						wrap_d = sat_inc(wrap_q);
					end
					last_d       = item.first_cycle;
					end_d        = item.first_cycle;
					run_active_d = 1'b0;
					if (item.abort_flag) run_aborted_d = 1'b1;
				end
			end
			OP_MOVE: begin
				if (move_en) begin
					// Entry stamp, then exit stamp, each checked for a wrap.
					if (item.first_cycle < last_q) begin
						if (wrap_d == '1) sticky_d[SF_WRAP] = 1'b1;
						wrap_d = sat_inc(wrap_d);
					end
					if (item.second_cycle < item.first_cycle) begin
						if (wrap_d == '1) sticky_d[SF_WRAP] = 1'b1;
						wrap_d = sat_inc(wrap_d);
					end
					last_d = item.second_cycle;

					if (entries_q == '1) sticky_d[SF_ENTRIES] = 1'b1;
					entries_d = sat_inc(entries_q);

					if (|ph_sat) sticky_d[SF_PHASE] = 1'b1;
					if ((|ph_hit) && (elapsed > overall_max_q)) begin
						overall_max_d = elapsed;
					end

					if (item.move_flags[MF_PULSE]) begin
						if (pulses_q == '1) sticky_d[SF_PULSES] = 1'b1;
						pulses_d = sat_inc(pulses_q);
					end

					if (item.move_flags[MF_PENDING]) begin
						if (pending_q == '1) sticky_d[SF_PENDING] = 1'b1;
						pending_d = sat_inc(pending_q);
						if (streak_q == '1) sticky_d[SF_STREAK] = 1'b1;
						streak_d = sat_inc(streak_q);
						if (streak_d > longest_q) longest_d = streak_d;
					end else begin
						streak_d = '0;
					end

					if (item.move_flags[MF_COMPLETE]) begin
						end_d        = item.second_cycle;
						run_active_d = 1'b0;
					end
				end
			end
			OP_IRQ: begin
				if (run_valid_q) begin
					if (!item.irq_flags[IF_ENTRY]) begin
						if (irq_missing_q == '1) sticky_d[SF_MISSING] = 1'b1;
						irq_missing_d = sat_inc(irq_missing_q);
					end else begin
						if (irq_samples_q == '1) sticky_d[SF_IRQ] = 1'b1;
						irq_samples_d = sat_inc(irq_samples_q);
						if (item.irq_flags[IF_TERMINAL]) begin
							if (elapsed > irq_term_q) irq_term_d = elapsed;
						end else begin
							if (elapsed > irq_active_q) irq_active_d = elapsed;
						end
						if (!item.irq_flags[IF_ETIMER]
							|| (item.entry_timer_count > item.entry_timer_reload)) begin
							if (irq_missing_q == '1) sticky_d[SF_MISSING] = 1'b1;
							irq_missing_d = sat_inc(irq_missing_q);
						end else begin
							if (item.entry_timer_count > ecount_max_q) begin
								ecount_max_d = item.entry_timer_count;
							end
							// Terminal interrupts carry no deadline check.
							if (!item.irq_flags[IF_TERMINAL]) begin
								if (!item.irq_flags[IF_PTIMER]
									|| (item.post_timer_count > item.post_timer_reload)) begin
									if (dl_misses_q == '1) sticky_d[SF_DL_MISSES] = 1'b1;
									dl_misses_d = sat_inc(dl_misses_q);
								end else begin
									if (dl_samples_q == '1) sticky_d[SF_DL_SAMPLE] = 1'b1;
									dl_samples_d = sat_inc(dl_samples_q);
									if (item.irq_flags[IF_PENDING]) begin
										if (dl_misses_q == '1) sticky_d[SF_DL_MISSES] = 1'b1;
										dl_misses_d = sat_inc(dl_misses_q);
									end else if (slack < least_q) begin
										least_d = slack;
									end
								end
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Statistic read. A read changes no state, so it sees the current values.
	always_comb begin
		logic [5:0]  sel;
		logic [5:0]  other;
		logic [63:0] rv;

		sel   = {1'b0, item.stat_select};
		other = sel - OTHER_BASE;
		rv    = '0;
		case (item.stat_select)
			STAT_START:    rv = 64'(start_q);
			STAT_END:      rv = 64'(end_q);
			STAT_WRAPS:    rv = 64'(wrap_q);
			STAT_DURATION: begin
				// The extended end is {wrap, end}; it lies below the start
				// only when no wrap was seen and end < start.
				if ((wrap_q == '0) && (end_q < start_q)) begin
					rv = '0;
				end else begin
					rv = {wrap_q, end_q} - 64'(start_q);
				end
			end
			STAT_ENTRIES:  rv = 64'(entries_q);
			default: begin
				if (sel < OTHER_BASE) begin
					rv = rd_phase;
				end else begin
					case (other)
						ST_OVERALL_MAX:   rv = 64'(overall_max_q);
						ST_PULSES:        rv = 64'(pulses_q);
						ST_PENDING:       rv = 64'(pending_q);
						ST_LONGEST:       rv = 64'(longest_q);
						ST_IRQ_SAMPLES:   rv = 64'(irq_samples_q);
						ST_IRQ_MISSING:   rv = 64'(irq_missing_q);
						ST_IRQ_ACTIVE:    rv = 64'(irq_active_q);
						ST_IRQ_TERMINAL:  rv = 64'(irq_term_q);
						ST_ENTRY_CNT_MAX: rv = 64'(ecount_max_q);
						ST_DL_SAMPLES:    rv = 64'(dl_samples_q);
						ST_DL_MISSES:     rv = 64'(dl_misses_q);
						ST_LEAST_SLACK:   rv = 64'(least_q);
						default:          rv = '0;
					endcase
				end
			end
		endcase

		result.read_value       = (item.op == OP_READ) ? rv : '0;
		result.run_valid        = run_valid_d;
		result.run_active       = run_active_d;
		result.run_aborted      = run_aborted_d;
		result.saturation_flags = sticky_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q   <= 1'b0;
			run_active_q  <= 1'b0;
			run_aborted_q <= 1'b0;
			start_q       <= '0;
			end_q         <= '0;
			last_q        <= '0;
			wrap_q        <= '0;
			entries_q     <= '0;
			overall_max_q <= '0;
			pulses_q      <= '0;
			pending_q     <= '0;
			streak_q      <= '0;
			longest_q     <= '0;
			irq_samples_q <= '0;
			irq_missing_q <= '0;
			irq_active_q  <= '0;
			irq_term_q    <= '0;
			ecount_max_q  <= '0;
			dl_samples_q  <= '0;
			dl_misses_q   <= '0;
			least_q       <= '1;
			sticky_q      <= '0;
			for (int i = 0; i < PHASE_COUNT; i++) begin
				ph_cnt_q[i] <= '0;
				ph_max_q[i] <= '0;
			end
		end else if (adv) begin
			run_valid_q   <= run_valid_d;
			run_active_q  <= run_active_d;
			run_aborted_q <= run_aborted_d;
			start_q       <= start_d;
			end_q         <= end_d;
			last_q        <= last_d;
			wrap_q        <= wrap_d;
			entries_q     <= entries_d;
			overall_max_q <= overall_max_d;
			pulses_q      <= pulses_d;
			pending_q     <= pending_d;
			streak_q      <= streak_d;
			longest_q     <= longest_d;
			irq_samples_q <= irq_samples_d;
			irq_missing_q <= irq_missing_d;
			irq_active_q  <= irq_active_d;
			irq_term_q    <= irq_term_d;
			ecount_max_q  <= ecount_max_d;
			dl_samples_q  <= dl_samples_d;
			dl_misses_q   <= dl_misses_d;
			least_q       <= least_d;
			sticky_q      <= sticky_d;
			for (int i = 0; i < PHASE_COUNT; i++) begin
				ph_cnt_q[i] <= ph_cnt_d[i];
				ph_max_q[i] <= ph_max_d[i];
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
module testbench;
	import itsm_pkg::*;

	// The monitor is built with its default phase count, and the predictor below keeps one
	// counter and one maximum per phase to match it.
	localparam int PHASES = 4;

	// Statistic indexes after the per-phase blocks start here.
	localparam int STAT_TAIL = STAT_PHASE_BASE + 2 * PHASES;

	// Highest statistic index; it lies past the last statistic and must read as zero.
	localparam logic [SEL_W-1:0] STAT_UNUSED_TOP = 5'd31;

	// Operation codes the monitor must ignore.
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// Interrupt flags of a sample whose entry and both timer readings are valid.
	localparam logic [4:0] IRQ_GOOD = 5'((1 << IF_ENTRY) | (1 << IF_ETIMER) | (1 << IF_PTIMER));

	// Number of cycles the receiver holds off when the stimulus asks it to.
	localparam int HOLD_CYCLES = 300;

	// The run can never take this long, even with the slowest stall patterns.
	localparam int RUN_LIMIT = 5_000_000;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [SCALE_W-1:0] cfg_data;

	itsm_chan_if #(.payload_t(item_t)) evt_if ();
	itsm_chan_if #(.payload_t(result_t)) res_if ();

	isr_timing_statistics_monitor_unit #(.PHASE_COUNT(PHASES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_if),
		.res(res_if),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Event words waiting to be offered, and the results the predictor expects back, oldest
	// first. Every event word produces exactly one result word.
	item_t   pending_items[$];
	result_t expected_results[$];

	int fault_count = 0;
	int results_seen = 0;

	// ------------------------------------------------------------------------------------
	// Predictor state. This mirrors the statistics the monitor keeps, at the same widths.
	// ------------------------------------------------------------------------------------
	logic              run_on, run_live, run_killed;
	logic [31:0]       t_start, t_end, t_last;
	logic [31:0]       n_wraps, n_entries;
	logic [31:0]       n_phase[PHASES];
	logic [31:0]       d_phase_max[PHASES];
	logic [31:0]       d_overall_max, n_pulses, n_pending, cur_streak, best_streak;
	logic [31:0]       n_irq, n_irq_missing, d_irq_active_max, d_irq_terminal_max;
	logic [15:0]       entry_count_peak;
	logic [31:0]       n_dl_samples, n_dl_misses, slack_floor;
	logic [SF_W-1:0]   sat_seen;
	logic [SCALE_W-1:0] tick_scale;

	// Returns every statistic to its cleared value. The tick scale is not touched, since a
	// new run keeps the register.
	function automatic void clear_stats();
		run_on = 1'b0;
		run_live = 1'b0;
		run_killed = 1'b0;
		t_start = '0;
		t_end = '0;
		t_last = '0;
		n_wraps = '0;
		n_entries = '0;
		for (int i = 0; i < PHASES; i++) begin
			n_phase[i] = '0;
			d_phase_max[i] = '0;
		end
		d_overall_max = '0;
		n_pulses = '0;
		n_pending = '0;
		cur_streak = '0;
		best_streak = '0;
		n_irq = '0;
		n_irq_missing = '0;
		d_irq_active_max = '0;
		d_irq_terminal_max = '0;
		entry_count_peak = '0;
		n_dl_samples = '0;
		n_dl_misses = '0;
		slack_floor = '1;
		sat_seen = '0;
	endfunction

	// A counter that is already all ones stays there and raises its sticky flag instead.
	function automatic void count_up(inout logic [31:0] cnt, input int flag);
		if (cnt == '1)
			sat_seen[flag] = 1'b1;
		else
			cnt = cnt + 32'd1;
	endfunction

	// Any stamp below the previous one is taken as a wrap of the cycle counter.
	function automatic void note_stamp(input logic [31:0] stamp);
		if (stamp < t_last)
			count_up(n_wraps, SF_WRAP);
		t_last = stamp;
	endfunction

	function automatic void log_move(input item_t w);
		logic [31:0] span;
		if (!run_on || !run_live)
			return;
		note_stamp(w.first_cycle);
		note_stamp(w.second_cycle);
		count_up(n_entries, SF_ENTRIES);
		if (int'(w.phase) < PHASES) begin
			span = w.second_cycle - w.first_cycle;
			count_up(n_phase[w.phase], SF_PHASE);
			if (span > d_phase_max[w.phase])
				d_phase_max[w.phase] = span;
			if (span > d_overall_max)
				d_overall_max = span;
		end
		if (w.move_flags[MF_PULSE])
			count_up(n_pulses, SF_PULSES);
		if (w.move_flags[MF_PENDING]) begin
			count_up(n_pending, SF_PENDING);
			count_up(cur_streak, SF_STREAK);
			if (cur_streak > best_streak)
				best_streak = cur_streak;
		end else begin
			cur_streak = '0;
		end
		if (w.move_flags[MF_COMPLETE]) begin
			t_end = w.second_cycle;
			run_live = 1'b0;
		end
	endfunction

	// A full interrupt sample walks a chain of checks. Each failed check counts as a missing
	// sample or a deadline miss and ends the update there.
	function automatic void log_irq(input item_t w);
		logic [31:0] span;
		logic [31:0] slack;
		if (!run_on)
			return;
		if (!w.irq_flags[IF_ENTRY]) begin
			count_up(n_irq_missing, SF_MISSING);
			return;
		end
		count_up(n_irq, SF_IRQ);
		span = w.second_cycle - w.first_cycle;
		if (w.irq_flags[IF_TERMINAL]) begin
			if (span > d_irq_terminal_max)
				d_irq_terminal_max = span;
		end else begin
			if (span > d_irq_active_max)
				d_irq_active_max = span;
		end
		if (!w.irq_flags[IF_ETIMER] || w.entry_timer_count > w.entry_timer_reload) begin
			count_up(n_irq_missing, SF_MISSING);
			return;
		end
		if (w.entry_timer_count > entry_count_peak)
			entry_count_peak = w.entry_timer_count;
		if (w.irq_flags[IF_TERMINAL])
			return;
		if (!w.irq_flags[IF_PTIMER] || w.post_timer_count > w.post_timer_reload) begin
			count_up(n_dl_misses, SF_DL_MISSES);
			return;
		end
		count_up(n_dl_samples, SF_DL_SAMPLE);
		if (w.irq_flags[IF_PENDING]) begin
			count_up(n_dl_misses, SF_DL_MISSES);
			return;
		end
		// Ticks left, counted inclusively, scaled to core cycles. The product fits 32 bits.
		slack = (32'(w.post_timer_reload) - 32'(w.post_timer_count) + 32'd1)
			* 32'(tick_scale);
		if (slack < slack_floor)
			slack_floor = slack;
	endfunction

	function automatic logic [63:0] stat_value(input logic [SEL_W-1:0] sel);
		int          idx;
		logic [63:0] stretched;
		logic [5:0]  rel;
		idx = int'(sel);
		if (sel == STAT_START)
			return 64'(t_start);
		if (sel == STAT_END)
			return 64'(t_end);
		if (sel == STAT_WRAPS)
			return 64'(n_wraps);
		if (sel == STAT_DURATION) begin
			// The end stamp is extended by the wrap count; an end below the start reads 0.
			stretched = {n_wraps, t_end};
			if (stretched < 64'(t_start))
				return '0;
			return stretched - 64'(t_start);
		end
		if (sel == STAT_ENTRIES)
			return 64'(n_entries);
		if (idx < STAT_PHASE_BASE + PHASES)
			return 64'(n_phase[idx - STAT_PHASE_BASE]);
		if (idx < STAT_TAIL)
			return 64'(d_phase_max[idx - STAT_PHASE_BASE - PHASES]);
		rel = 6'(idx - STAT_TAIL);
		case (rel)
			ST_OVERALL_MAX:   return 64'(d_overall_max);
			ST_PULSES:        return 64'(n_pulses);
			ST_PENDING:       return 64'(n_pending);
			ST_LONGEST:       return 64'(best_streak);
			ST_IRQ_SAMPLES:   return 64'(n_irq);
			ST_IRQ_MISSING:   return 64'(n_irq_missing);
			ST_IRQ_ACTIVE:    return 64'(d_irq_active_max);
			ST_IRQ_TERMINAL:  return 64'(d_irq_terminal_max);
			ST_ENTRY_CNT_MAX: return 64'(entry_count_peak);
			ST_DL_SAMPLES:    return 64'(n_dl_samples);
			ST_DL_MISSES:     return 64'(n_dl_misses);
			ST_LEAST_SLACK:   return 64'(slack_floor);
			default:          return '0;
		endcase
	endfunction

	// Applies one accepted event word and returns the result word it should produce.
	function automatic result_t apply_word(input item_t w);
		result_t r;
		r = '0;
		case (w.op)
			OP_START: begin
				clear_stats();
				run_on = 1'b1;
				run_live = 1'b1;
				t_start = w.first_cycle;
				t_end = w.first_cycle;
				t_last = w.first_cycle;
			end
			OP_ABORT: begin
				if (run_on)
					run_killed = 1'b1;
			end
			OP_FINISH: begin
				if (run_on) begin
					note_stamp(w.first_cycle);
					t_end = w.first_cycle;
					run_live = 1'b0;
					if (w.abort_flag)
						run_killed = 1'b1;
				end
			end
			OP_MOVE: log_move(w);
			OP_IRQ: log_irq(w);
			OP_READ: r.read_value = stat_value(w.stat_select);
			default: ;
		endcase
		r.run_valid = run_on;
		r.run_active = run_live;
		r.run_aborted = run_killed;
		r.saturation_flags = sat_seen;
		return r;
	endfunction

	// ------------------------------------------------------------------------------------
	// Driver. It offers words from pending_items in bursts of random length with random
	// gaps between them. A word stays on the channel until it is accepted; a new one is
	// loaded only when the slot is free, so valid is never dropped under a waiting word.
	// ------------------------------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!evt_if.valid || evt_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					evt_if.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					evt_if.data <= pending_items.pop_front();
					evt_if.valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						// Mostly short bursts, now and then a long unbroken stretch.
						burst_left = ($urandom_range(0, 4) == 0) ?
							$urandom_range(50, 150) : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					evt_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------------------
	// Receiver. The stall pattern is redrawn at random, on a tick counter, among always
	// ready, a coin flip, a fixed period and a heavy choke. A hold request from the stimulus
	// forces a long stretch with ready low, counted down in its own process.
	// ------------------------------------------------------------------------------------
	logic     hold_request;
	int       hold_left = 0;
	int       rx_tick = 0;
	rx_mode_e rx_mode = RX_FREE;
	logic     rx_go;

	always @(posedge clk) begin
		if (hold_request)
			hold_left <= HOLD_CYCLES;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 97 == 0)
			rx_mode = rx_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_FREE:     rx_go = 1'b1;
			RX_COIN:     rx_go = 1'($urandom_range(0, 1));
			RX_PERIODIC: rx_go = (rx_tick % 5) != 0;
			default:     rx_go = $urandom_range(0, 7) == 0;
		endcase
		res_if.ready <= rx_go && hold_left == 0 && arst_n;
	end

	// ------------------------------------------------------------------------------------
	// Monitor. At each edge it first checks a result word taken on the output channel
	// against the oldest expectation, then predicts the event word taken on the input
	// channel at the same edge. Doing both in one process keeps the order fixed.
	// ------------------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= 10)
				$display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result %0d arrived with nothing expected: %p",
							results_seen, res_if.data);
				end else begin
					want = expected_results.pop_front();
					check_field("read_value", want.read_value, res_if.data.read_value);
					check_field("run_valid", 64'(want.run_valid), 64'(res_if.data.run_valid));
					check_field("run_active", 64'(want.run_active),
						64'(res_if.data.run_active));
					check_field("run_aborted", 64'(want.run_aborted),
						64'(res_if.data.run_aborted));
					check_field("saturation_flags", 64'(want.saturation_flags),
						64'(res_if.data.saturation_flags));
				end
			end
			if (evt_if.valid && evt_if.ready)
				expected_results.push_back(apply_word(evt_if.data));
		end
	end

	// ------------------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------------------

	// Cycle stamp the current run has reached, so samples mostly move forward in time.
	logic [31:0] stamp_cursor = '0;

	// A word with every field random and the operation given. Fields an operation does not
	// use still toggle, which checks that the monitor ignores them.
	function automatic item_t word_of(input logic [2:0] op);
		item_t w;
		w.op = op;
		w.first_cycle = $urandom();
		w.second_cycle = $urandom();
		w.phase = 2'($urandom_range(0, 3));
		w.move_flags = 3'($urandom_range(0, 7));
		w.abort_flag = 1'($urandom_range(0, 1));
		w.irq_flags = 5'($urandom_range(0, 31));
		w.entry_timer_count = 16'($urandom_range(0, 65535));
		w.entry_timer_reload = 16'($urandom_range(0, 65535));
		w.post_timer_count = 16'($urandom_range(0, 65535));
		w.post_timer_reload = 16'($urandom_range(0, 65535));
		w.stat_select = SEL_W'($urandom_range(0, 31));
		return w;
	endfunction

	function automatic item_t move_word();
		item_t w;
		w = word_of(OP_MOVE);
		// Now and then the stamps jump to a random place, often backward, which counts
		// as a wrap.
		if ($urandom_range(0, 19) == 0)
			stamp_cursor = $urandom();
		w.first_cycle = stamp_cursor + $urandom_range(0, 2000);
		w.second_cycle = w.first_cycle + $urandom_range(0, 3000);
		if ($urandom_range(0, 29) == 0)
			w.second_cycle = $urandom();
		stamp_cursor = w.second_cycle;
		w.move_flags[MF_PENDING] = $urandom_range(0, 9) < 6;
		w.move_flags[MF_COMPLETE] = $urandom_range(0, 24) == 0;
		return w;
	endfunction

	function automatic item_t irq_word();
		item_t w;
		w = word_of(OP_IRQ);
		w.first_cycle = stamp_cursor + $urandom_range(0, 500);
		w.second_cycle = w.first_cycle + $urandom_range(0, 4000);
		// Most samples are well formed so that they reach the slack update; the rest keep
		// their random flags and timer readings.
		if ($urandom_range(0, 3) != 0) begin
			w.irq_flags = IRQ_GOOD;
			w.irq_flags[IF_PENDING] = $urandom_range(0, 4) == 0;
			w.irq_flags[IF_TERMINAL] = $urandom_range(0, 4) == 0;
			w.entry_timer_count = 16'($urandom_range(0, w.entry_timer_reload));
			if ($urandom_range(0, 2) == 0)
				w.post_timer_count = w.post_timer_reload - 16'($urandom_range(0, 8));
			else
				w.post_timer_count = 16'($urandom_range(0, w.post_timer_reload));
		end
		return w;
	endfunction

	// Queues one run: a start, a random mix of samples, reads and control words, then
	// in about half the runs a finish, and a few reads.
	task automatic queue_run(output int added);
		item_t w;
		int    events;
		int    pick;
		added = 0;
		w = word_of(OP_START);
		if ($urandom_range(0, 3) == 0)
			w.first_cycle = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		stamp_cursor = w.first_cycle;
		pending_items.push_back(w);
		added++;
		events = $urandom_range(4, 40);
		repeat (events) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				w = move_word();
			end else if (pick < 65) begin
				w = irq_word();
			end else if (pick < 85) begin
				w = word_of(OP_READ);
			end else if (pick < 89) begin
				w = word_of(OP_ABORT);
			end else if (pick < 93) begin
				w = word_of(OP_FINISH);
				w.first_cycle = stamp_cursor + $urandom_range(0, 1000);
			end else begin
				// Noise: any operation code, unused ones included, with random content.
				w = word_of(3'($urandom_range(0, 7)));
			end
			pending_items.push_back(w);
			added++;
		end
		if ($urandom_range(0, 1) == 0) begin
			w = word_of(OP_FINISH);
			w.first_cycle = stamp_cursor + $urandom_range(0, 1000);
			pending_items.push_back(w);
			added++;
		end
		repeat ($urandom_range(3, 6)) begin
			pending_items.push_back(word_of(OP_READ));
			added++;
		end
	endtask

	// Waits until every queued word has been taken and every result has come back.
	task automatic wait_idle();
		while (pending_items.size() != 0 || evt_if.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the tick scale. The monitor is idle here, so the predictor can take the new
	// value at once.
	task automatic write_scale(input logic [SCALE_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		tick_scale = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Random part of one phase. With style 1 the receiver is held off once the driver has
	// work queued, so the monitor fills and stalls its input. With style 2 the sender stops
	// halfway until every expected result has arrived.
	task automatic random_phase(input int quota, input int style);
		int queued;
		int added;
		queued = 0;
		while (queued < quota) begin
			queue_run(added);
			queued += added;
			if (style == 1 && queued >= quota / 3 && queued - added < quota / 3) begin
				@(posedge clk);
				hold_request <= 1'b1;
				@(posedge clk);
				hold_request <= 1'b0;
			end
			if (style == 2 && queued >= quota / 2 && queued - added < quota / 2)
				wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------------------
	// Main sequence: reset, a directed pass at the reset scale, then random phases under
	// several tick scales, the extremes included.
	// ------------------------------------------------------------------------------------
	initial begin : stimulus
		item_t              w;
		logic [SCALE_W-1:0] scales[5];

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = SCALE_RESET;
		hold_request = 1'b0;
		evt_if.valid = 1'b0;
		evt_if.data = '0;
		res_if.ready = 1'b0;
		clear_stats();
		tick_scale = SCALE_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads before any run return the reset values, least slack as all ones, and an
		// index past the last statistic reads zero.
		w = word_of(OP_READ);
		w.stat_select = SEL_W'(STAT_TAIL + ST_LEAST_SLACK);
		pending_items.push_back(w);
		w = word_of(OP_READ);
		w.stat_select = STAT_UNUSED_TOP;
		pending_items.push_back(w);

		// With no run started, everything but start and read is ignored, and so are the
		// unused operation codes.
		pending_items.push_back(word_of(OP_MOVE));
		w = word_of(OP_IRQ);
		w.irq_flags = IRQ_GOOD;
		pending_items.push_back(w);
		w = word_of(OP_FINISH);
		w.abort_flag = 1'b1;
		pending_items.push_back(w);
		pending_items.push_back(word_of(OP_ABORT));
		pending_items.push_back(word_of(OP_SPARE6));
		pending_items.push_back(word_of(OP_SPARE7));

		// A run that starts just below the top of the stamp range.
		w = word_of(OP_START);
		w.first_cycle = 32'hFFFF_FFF0;
		pending_items.push_back(w);

		// The exit stamp wraps past zero.
		w = word_of(OP_MOVE);
		w.phase = 2'd0;
		w.first_cycle = 32'hFFFF_FFF8;
		w.second_cycle = 32'h0000_0010;
		w.move_flags = 3'((1 << MF_PENDING) | (1 << MF_PULSE));
		pending_items.push_back(w);

		// Widest possible span, from stamp zero to all ones.
		w = word_of(OP_MOVE);
		w.phase = 2'd3;
		w.first_cycle = '0;
		w.second_cycle = '1;
		w.move_flags = 3'(1 << MF_PENDING);
		pending_items.push_back(w);

		// No pending bit: the streak starts over.
		w = word_of(OP_MOVE);
		w.phase = 2'd1;
		w.first_cycle = '1;
		w.second_cycle = '1;
		w.move_flags = '0;
		pending_items.push_back(w);

		// Largest slack: post count zero against a full reload.
		w = word_of(OP_IRQ);
		w.irq_flags = IRQ_GOOD;
		w.entry_timer_count = '0;
		w.entry_timer_reload = '1;
		w.post_timer_count = '0;
		w.post_timer_reload = '1;
		pending_items.push_back(w);

		// Terminal sample with the entry count at its top.
		w = word_of(OP_IRQ);
		w.irq_flags = IRQ_GOOD | 5'(1 << IF_TERMINAL);
		w.entry_timer_count = '1;
		w.entry_timer_reload = '1;
		pending_items.push_back(w);

		// Entry not valid: a missing sample.
		w = word_of(OP_IRQ);
		w.irq_flags = '0;
		pending_items.push_back(w);

		// Entry count above its reload.
		w = word_of(OP_IRQ);
		w.irq_flags = IRQ_GOOD;
		w.entry_timer_count = 16'd9;
		w.entry_timer_reload = 16'd8;
		pending_items.push_back(w);

		// Post count above its reload: a deadline miss.
		w = word_of(OP_IRQ);
		w.irq_flags = IRQ_GOOD;
		w.entry_timer_count = '0;
		w.post_timer_count = '1;
		w.post_timer_reload = 16'hFFFE;
		pending_items.push_back(w);

		// Update still pending after the handler: also a deadline miss.
		w = word_of(OP_IRQ);
		w.irq_flags = IRQ_GOOD | 5'(1 << IF_PENDING);
		w.entry_timer_count = '0;
		w.post_timer_count = 16'd3;
		w.post_timer_reload = 16'd3;
		pending_items.push_back(w);

		w = word_of(OP_READ);
		w.stat_select = STAT_DURATION;
		pending_items.push_back(w);
		w = word_of(OP_READ);
		w.stat_select = STAT_WRAPS;
		pending_items.push_back(w);

		// A completed move ends the run; the next move sample is ignored while interrupt
		// samples, abort and finish still act.
		w = move_word();
		w.phase = 2'd2;
		w.move_flags[MF_COMPLETE] = 1'b1;
		pending_items.push_back(w);
		pending_items.push_back(move_word());
		pending_items.push_back(irq_word());
		pending_items.push_back(word_of(OP_ABORT));
		w = word_of(OP_FINISH);
		w.first_cycle = '0;
		w.abort_flag = 1'b0;
		pending_items.push_back(w);
		w = word_of(OP_READ);
		w.stat_select = STAT_DURATION;
		pending_items.push_back(w);
		w = word_of(OP_READ);
		w.stat_select = SEL_W'(STAT_TAIL + ST_LEAST_SLACK);
		pending_items.push_back(w);
		wait_idle();

		// Random phases. The first runs at the reset scale; the others cover zero, sixteen,
		// the top value, one and one random setting.
		random_phase(130, 1);
		scales[0] = '0;
		scales[1] = 5'd16;
		scales[2] = '1;
		scales[3] = 5'd1;
		scales[4] = SCALE_W'($urandom_range(0, 31));
		for (int i = 0; i < 5; i++) begin
			wait_idle();
			write_scale(scales[i]);
			random_phase(130, (i == 1) ? 1 : (i == 2) ? 2 : 0);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Safety net for a hung handshake.
	initial begin
		#(RUN_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule
